// File: design/axis_rotate_with_face_normal_assert.svh
// ---------------------------------------------------------------------------
// assertion macros for the vertex rotation block
// ---------------------------------------------------------------------------
`ifndef AXIS_ROTATE_WITH_FACE_NORMAL_ASSERT_SVH
`define AXIS_ROTATE_WITH_FACE_NORMAL_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define ARWFN_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ARWFN_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: design/arwfn_pkg.sv
// ---------------------------------------------------------------------------
// arwfn_pkg
// shared types, constants and helper functions of the vertex rotation block
// ---------------------------------------------------------------------------
`default_nettype none

package arwfn_pkg;

   // cordic configuration
   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_USED  = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
   localparam logic [4:0] CORDIC_LAST = 5'(CORDIC_USED - 1);

   // angle constants in units of 1/128 degree
   localparam logic signed [17:0] DEG90  = 18'sd11520;
   localparam logic signed [17:0] DEG180 = 18'sd23040;
   localparam logic signed [17:0] DEG270 = 18'sd34560;
   localparam logic signed [17:0] DEG360 = 18'sd46080;

   localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
   localparam logic signed [17:0] Q16_ONE   = 18'sd65536;

   // register indexes
   localparam logic REG_AXIS  = 1'b0;
   localparam logic REG_ANGLE = 1'b1;

   // rotation axis codes
   localparam logic [1:0] AXIS_NONE = 2'd0;
   localparam logic [1:0] AXIS_X    = 2'd1;
   localparam logic [1:0] AXIS_Y    = 2'd2;
   localparam logic [1:0] AXIS_Z    = 2'd3;

   // control of the shared multiply-accumulate unit
   typedef struct packed {
      logic mul_en;
      logic acc_en;
      logic clear;
      logic negate;
   } mac_ctrl_type;

   // atan(2^-i) in units of 2^-20 degree
   function automatic logic [26:0] atan_entry(input logic [4:0] i);
      logic [26:0] v;
      case (i)
         5'd0:    v = 27'd47185920;
         5'd1:    v = 27'd27855475;
         5'd2:    v = 27'd14718068;
         5'd3:    v = 27'd7471121;
         5'd4:    v = 27'd3750059;
         5'd5:    v = 27'd1876857;
         5'd6:    v = 27'd938658;
         5'd7:    v = 27'd469358;
         5'd8:    v = 27'd234682;
         5'd9:    v = 27'd117342;
         5'd10:   v = 27'd58671;
         5'd11:   v = 27'd29336;
         5'd12:   v = 27'd14668;
         5'd13:   v = 27'd7334;
         5'd14:   v = 27'd3667;
         5'd15:   v = 27'd1833;
         5'd16:   v = 27'd917;
         5'd17:   v = 27'd458;
         5'd18:   v = 27'd229;
         5'd19:   v = 27'd115;
         5'd20:   v = 27'd57;
         5'd21:   v = 27'd29;
         5'd22:   v = 27'd14;
         5'd23:   v = 27'd7;
         default: v = 27'd0;
      endcase
      return v;
   endfunction

   // round half up by 16 bits, then saturate to 32 bits
   function automatic logic signed [31:0] round_sat(input logic signed [65:0] acc);
      logic signed [65:0] t;
      logic signed [49:0] s;
      t = acc + 66'sd32768;
      s = 50'(t >>> 16);
      if (s > 50'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (s < -50'sd2147483648) begin
         return 32'sh80000000;
      end
      return 32'(s);
   endfunction

   // difference clamped to +-(2^31-1)
   function automatic logic signed [31:0] sdiff(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      logic signed [32:0] d;
      d = 33'(a) - 33'(b);
      if (d > 33'sd2147483647) begin
         return 32'sd2147483647;
      end else if (d < -33'sd2147483647) begin
         return -32'sd2147483647;
      end
      return 32'(d);
   endfunction

endpackage

`default_nettype wire

// File: design/arwfn_cordic.sv
// ---------------------------------------------------------------------------
// arwfn_cordic
// iterative cordic: one micro-rotation per cycle, cosine and sine in Q1.16
// ---------------------------------------------------------------------------
`default_nettype none

module arwfn_cordic import arwfn_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [16:0] angle,
   output logic                    done,
   output logic signed [17:0]      cos_out,
   output logic signed [17:0]      sin_out
);

   typedef enum logic [2:0] {
      CS_IDLE = 3'b001,
      CS_RUN  = 3'b010,
      CS_DONE = 3'b100
   } cstate_type;

   cstate_type              state_ff, state_in;
   logic [4:0]              step_ff, step_in;
   logic signed [33:0]      x_ff, x_in, y_ff, y_in;
   logic signed [28:0]      z_ff, z_in;
   logic                    neg_ff, neg_in;
   logic signed [17:0]      r_mod, r_pos, r_fold;
   logic                    r_neg;
   logic signed [33:0]      dx, dy;
   logic signed [28:0]      atan_s;
   logic signed [19:0]      cos_r, sin_r;
   logic signed [17:0]      cos_c, sin_c;

   // angle reduction and folding into [-90, 90]
   always_comb begin
      r_mod = 18'(angle);
      if (r_mod >= DEG360) begin
         r_mod = r_mod - DEG360;
      end else if (r_mod <= -DEG360) begin
         r_mod = r_mod + DEG360;
      end
      r_pos = (r_mod < 0) ? r_mod + DEG360 : r_mod;
      r_neg = 1'b0;
      r_fold = r_pos;
      if (r_pos > DEG90 && r_pos <= DEG270) begin
         r_fold = r_pos - DEG180;
         r_neg = 1'b1;
      end else if (r_pos > DEG270) begin
         r_fold = r_pos - DEG360;
      end
   end

   // one micro-rotation
   assign dx     = y_ff >>> step_ff;
   assign dy     = x_ff >>> step_ff;
   assign atan_s = 29'(atan_entry(step_ff));

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      neg_in   = neg_ff;
      case (state_ff)
         CS_IDLE: begin
            if (start) begin
               x_in     = CORDIC_X0;
               y_in     = '0;
               z_in     = 29'(r_fold) <<< 13;
               neg_in   = r_neg;
               step_in  = '0;
               state_in = CS_RUN;
            end
         end
         CS_RUN: begin
            if (z_ff >= 0) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - atan_s;
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + atan_s;
            end
            step_in = step_ff + 5'd1;
            if (step_ff == CORDIC_LAST) begin
               state_in = CS_DONE;
            end
         end
         CS_DONE: begin
            state_in = CS_IDLE;
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      neg_ff  <= neg_in;
   end

   // rounding to Q1.16, clamping and quadrant sign
   always_comb begin
      cos_r = 20'((x_ff + 34'sd8192) >>> 14);
      sin_r = 20'((y_ff + 34'sd8192) >>> 14);
      cos_c = (cos_r > 20'(Q16_ONE)) ? Q16_ONE :
              (cos_r < -20'(Q16_ONE)) ? -Q16_ONE : 18'(cos_r);
      sin_c = (sin_r > 20'(Q16_ONE)) ? Q16_ONE :
              (sin_r < -20'(Q16_ONE)) ? -Q16_ONE : 18'(sin_r);
   end

   assign done    = (state_ff == CS_DONE);
   assign cos_out = neg_ff ? -cos_c : cos_c;
   assign sin_out = neg_ff ? -sin_c : sin_c;

endmodule

`default_nettype wire

// File: design/arwfn_mac.sv
// ---------------------------------------------------------------------------
// arwfn_mac
// shared 32x32 multiplier with registered product and 66-bit accumulator
// ---------------------------------------------------------------------------
`default_nettype none

module arwfn_mac import arwfn_pkg::*; (
   input  wire logic               clock,
   input  wire mac_ctrl_type       ctrl,
   input  wire logic signed [31:0] op_a,
   input  wire logic signed [31:0] op_b,
   output logic signed [31:0]      result
);

   logic signed [63:0] prod_ff;
   logic signed [65:0] acc_ff, acc_in, addend;

   // accumulate or start over with the signed product
   always_comb begin
      addend = ctrl.negate ? -66'(prod_ff) : 66'(prod_ff);
      acc_in = (ctrl.clear ? 66'sd0 : acc_ff) + addend;
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= op_a * op_b;
      end
      if (ctrl.acc_en) begin
         acc_ff <= acc_in;
      end
   end

   assign result = round_sat(acc_ff);

endmodule

`default_nettype wire

// File: design/axis_rotate_with_face_normal.sv
// ---------------------------------------------------------------------------
// axis_rotate_with_face_normal
// rotates Q16.16 vertices about one axis and gives a face normal per quad
// ---------------------------------------------------------------------------
// usage:
//   req_ carries one vertex per transfer, rsp_ one rotated vertex per
//   transfer; every fourth response has quad_done set with the normal of
//   (v0-v1) x (v2-v1), otherwise the normal fields are zero.
//   csr_ writes axis (index 0) or angle (index 1) while the block is idle.
// sequencing:
//   one vertex at a time through one shared 32x32 multiplier; each product
//   takes ST_MUL and ST_ACC, plus one ST_WB write-back per result word.
//   rotated vertex: products and a write-back per rotated coordinate, then ST_OUT; axis none: straight to ST_OUT.
//   third vertex of a quad adds 6 products for the cross product.
//   first vertex after a csr write adds the cordic run (ST_TRIG).
//   the next request is taken once the response has been transferred.
// reset:
//   axis and angle clear, the quad slot returns to zero, trig is recomputed
// stall:
//   rsp payload holds while rsp_ready is low; req_ready stays low
// ---------------------------------------------------------------------------
`default_nettype none

module axis_rotate_with_face_normal import arwfn_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   // configuration
   input  wire logic               csr_write_en,
   input  wire logic               csr_index,
   input  wire logic [16:0]        csr_data,
   // vertex in
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [31:0] req_in_x,
   input  wire logic signed [31:0] req_in_y,
   input  wire logic signed [31:0] req_in_z,
   // vertex out
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_out_x,
   output logic signed [31:0]      rsp_out_y,
   output logic signed [31:0]      rsp_out_z,
   output logic signed [31:0]      rsp_normal_x,
   output logic signed [31:0]      rsp_normal_y,
   output logic signed [31:0]      rsp_normal_z,
   output logic                    rsp_quad_done
);

`include "axis_rotate_with_face_normal_assert.svh"

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_TRIG = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_ACC  = 6'b001000,
      ST_WB   = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   state_type               state_ff, state_in;
   logic [3:0]              op_ff, op_in;
   logic [1:0]              axis_ff;
   logic signed [16:0]      angle_ff;
   logic                    trig_ready_ff;
   logic signed [17:0]      cos_ff, sin_ff;
   logic [1:0]              slot_ff;
   logic signed [31:0]      v_ff [3];
   logic signed [31:0]      w_ff [3];
   logic signed [31:0]      first_ff [3];
   logic signed [31:0]      second_ff [3];
   logic signed [31:0]      normal_ff [3];
   logic                    rsp_valid_ff;

   logic                    req_fire;
   logic                    cordic_start, cordic_done;
   logic signed [17:0]      cordic_cos, cordic_sin;
   mac_ctrl_type            mac_ctrl;
   logic signed [31:0]      op_a, op_b, mac_result;
   logic [1:0]              idx_a, idx_b, idx_p, idx_q;
   logic signed [31:0]      va, vb, trig_c, trig_s;
   logic                    op_fin, op_neg, op_clr;
   logic [3:0]              first_op;
   logic                    has_first_op;

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_fire  = req_valid && req_ready;

   // configuration registers and trig cache
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff       <= AXIS_NONE;
         angle_ff      <= '0;
         trig_ready_ff <= 1'b0;
         cos_ff        <= Q16_ONE;
         sin_ff        <= '0;
      end else if (csr_write_en) begin
         trig_ready_ff <= 1'b0;
         case (csr_index)
            REG_AXIS:  axis_ff  <= csr_data[1:0];
            REG_ANGLE: angle_ff <= csr_data;
            default:   axis_ff  <= axis_ff;
         endcase
      end else if (cordic_done) begin
         trig_ready_ff <= 1'b1;
         cos_ff        <= cordic_cos;
         sin_ff        <= cordic_sin;
      end
   end

   assign cordic_start = req_fire && !trig_ready_ff;

   arwfn_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .angle   (angle_ff),
      .done    (cordic_done),
      .cos_out (cordic_cos),
      .sin_out (cordic_sin)
   );

   // rotation pair of coordinates for the axis
   always_comb begin
      case (axis_ff)
         AXIS_X:  begin idx_a = 2'd1; idx_b = 2'd2; end
         AXIS_Y:  begin idx_a = 2'd0; idx_b = 2'd2; end
         AXIS_Z:  begin idx_a = 2'd0; idx_b = 2'd1; end
         default: begin idx_a = 2'd0; idx_b = 2'd0; end
      endcase
   end

   assign va     = v_ff[idx_a];
   assign vb     = v_ff[idx_b];
   assign trig_c = 32'(cos_ff);
   assign trig_s = 32'(sin_ff);

   // cross product operand indexes, p from corners, q from current vertex
   always_comb begin
      case (op_ff)
         4'd4:    begin idx_p = 2'd1; idx_q = 2'd2; end
         4'd5:    begin idx_p = 2'd2; idx_q = 2'd1; end
         4'd6:    begin idx_p = 2'd2; idx_q = 2'd0; end
         4'd7:    begin idx_p = 2'd0; idx_q = 2'd2; end
         4'd8:    begin idx_p = 2'd0; idx_q = 2'd1; end
         4'd9:    begin idx_p = 2'd1; idx_q = 2'd0; end
         default: begin idx_p = 2'd0; idx_q = 2'd0; end
      endcase
   end

   // operand selection per micro-op
   always_comb begin
      case (op_ff)
         4'd0:    begin op_a = trig_c; op_b = va; end
         4'd1:    begin op_a = trig_s; op_b = vb; end
         4'd2:    begin op_a = trig_s; op_b = va; end
         4'd3:    begin op_a = trig_c; op_b = vb; end
         default: begin
            op_a = sdiff(first_ff[idx_p], second_ff[idx_p]);
            op_b = sdiff(w_ff[idx_q], second_ff[idx_q]);
         end
      endcase
   end

   assign op_fin = op_ff[0];
   assign op_clr = !op_ff[0];
   assign op_neg = (op_ff == 4'd1) || (op_ff == 4'd5) || (op_ff == 4'd7)
                   || (op_ff == 4'd9);

   // first micro-op of a vertex
   always_comb begin
      has_first_op = 1'b1;
      first_op     = 4'd0;
      if (axis_ff == AXIS_NONE) begin
         first_op = 4'd4;
         has_first_op = (slot_ff == 2'd2);
      end
   end

   always_comb begin
      mac_ctrl        = '0;
      mac_ctrl.mul_en = (state_ff == ST_MUL);
      mac_ctrl.acc_en = (state_ff == ST_ACC);
      mac_ctrl.clear  = op_clr;
      mac_ctrl.negate = op_neg;
   end

   arwfn_mac u_mac (
      .clock  (clock),
      .ctrl   (mac_ctrl),
      .op_a   (op_a),
      .op_b   (op_b),
      .result (mac_result)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in = first_op;
               if (!trig_ready_ff) begin
                  state_in = ST_TRIG;
               end else begin
                  state_in = has_first_op ? ST_MUL : ST_OUT;
               end
            end
         end
         ST_TRIG: begin
            if (cordic_done) begin
               state_in = has_first_op ? ST_MUL : ST_OUT;
            end
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (op_fin) begin
               state_in = ST_WB;
            end else begin
               op_in    = op_ff + 4'd1;
               state_in = ST_MUL;
            end
         end
         ST_WB: begin
            if (op_ff == 4'd9 || (op_ff == 4'd3 && slot_ff != 2'd2)) begin
               state_in = ST_OUT;
            end else begin
               op_in    = op_ff + 4'd1;
               state_in = ST_MUL;
            end
         end
         ST_OUT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slot_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_OUT) begin
            slot_ff <= slot_ff + 2'd1;
         end
      end
      op_ff <= op_in;
   end

   // vertex capture and result write-back
   always_ff @(posedge clock) begin
      if (req_fire) begin
         v_ff[0] <= req_in_x;
         v_ff[1] <= req_in_y;
         v_ff[2] <= req_in_z;
         w_ff[0] <= req_in_x;
         w_ff[1] <= req_in_y;
         w_ff[2] <= req_in_z;
      end
      if (state_ff == ST_WB) begin
         case (op_ff)
            4'd1:    w_ff[idx_a]  <= mac_result;
            4'd3:    w_ff[idx_b]  <= mac_result;
            4'd5:    normal_ff[0] <= mac_result;
            4'd7:    normal_ff[1] <= mac_result;
            4'd9:    normal_ff[2] <= mac_result;
            default: normal_ff[0] <= normal_ff[0];
         endcase
      end
      if (state_ff == ST_OUT) begin
         if (slot_ff == 2'd0) begin
            first_ff <= w_ff;
         end
         if (slot_ff == 2'd1) begin
            second_ff <= w_ff;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (state_ff == ST_OUT) begin
         rsp_out_x     <= w_ff[0];
         rsp_out_y     <= w_ff[1];
         rsp_out_z     <= w_ff[2];
         rsp_quad_done <= (slot_ff == 2'd3);
         rsp_normal_x  <= (slot_ff == 2'd3) ? normal_ff[0] : '0;
         rsp_normal_y  <= (slot_ff == 2'd3) ? normal_ff[1] : '0;
         rsp_normal_z  <= (slot_ff == 2'd3) ? normal_ff[2] : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // checks
   `ARWFN_ASSERT_IMP(a_one_in_flight, clock, reset, req_ready, !rsp_valid)
   `ARWFN_ASSERT_IMP(a_trig_wait, clock, reset, state_ff == ST_TRIG, !trig_ready_ff)
   `ARWFN_ASSERT_NEXT(a_quad_slot, clock, reset,
      state_ff == ST_OUT && slot_ff == 2'd3, rsp_quad_done && slot_ff == 2'd0)
   `ARWFN_ASSERT_IMP(a_cross_only_slot2, clock, reset,
      state_ff == ST_MUL && op_ff >= 4'd4, slot_ff == 2'd2)

endmodule

`default_nettype wire
